/* rtl/pesp_pkg.sv */
package pesp_pkg;

  // Result status codes.
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  // Stream kind codes.
  localparam logic [2:0] KIND_PRIV1   = 3'd0;
  localparam logic [2:0] KIND_PADDING = 3'd1;
  localparam logic [2:0] KIND_PRIV2   = 3'd2;
  localparam logic [2:0] KIND_AUDIO   = 3'd3;
  localparam logic [2:0] KIND_VIDEO   = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  // Stream id values and ranges.
  localparam logic [7:0] ID_PRIV1     = 8'hBD;
  localparam logic [7:0] ID_PADDING   = 8'hBE;
  localparam logic [7:0] ID_PRIV2     = 8'hBF;
  localparam logic [7:0] ID_AUDIO_LO  = 8'hC0;
  localparam logic [7:0] ID_AUDIO_HI  = 8'hDF;
  localparam logic [7:0] ID_VIDEO_LO  = 8'hE0;
  localparam logic [7:0] ID_VIDEO_HI  = 8'hEF;

  // PTS/DTS indicator codes.
  localparam logic [1:0] TS_IND_PTS     = 2'd2;
  localparam logic [1:0] TS_IND_PTS_DTS = 2'd3;

  // Byte positions within the header.
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_PREFIX_END = 9'd3;
  localparam logic [POS_W-1:0] POS_ID         = 9'd3;
  localparam logic [POS_W-1:0] POS_LEN_END    = 9'd6;
  localparam logic [POS_W-1:0] POS_FLAGS_END  = 9'd8;
  localparam logic [POS_W-1:0] POS_HDR_LEN    = 9'd8;
  localparam logic [POS_W-1:0] POS_TS         = 9'd9;
  localparam logic [POS_W-1:0] POS_PTS_DONE   = 9'd14;
  localparam logic [POS_W-1:0] POS_DTS_DONE   = 9'd19;
  localparam logic [POS_W-1:0] POS_MAX        = 9'd264;
  localparam logic [POS_W-1:0] TS_ONE_LEN     = 9'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [23:0] start_prefix;
    logic [7:0]  stream_id;
    logic [15:0] pes_length;
    logic [2:0]  stream_kind;
    logic        has_extension;
    logic [15:0] extension_flags;
    logic [7:0]  header_data_length;
    logic        pts_valid;
    logic [32:0] pts_value;
    logic        dts_valid;
    logic [32:0] dts_value;
  } out_item_t;

  // Header gathering state.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [23:0]      prefix;
    logic [7:0]       id;
    logic [15:0]      length;
    logic [15:0]      flags;
    logic [7:0]       hdr_len;
    logic [32:0]      pts;
    logic [32:0]      dts;
  } hdr_state_t;

  // Sort a stream id into its kind.
  function automatic logic [2:0] kind_of(input logic [7:0] id);
    logic [2:0] k;
    if (id == ID_PRIV1) k = KIND_PRIV1;
    else if (id == ID_PADDING) k = KIND_PADDING;
    else if (id == ID_PRIV2) k = KIND_PRIV2;
    else if (id >= ID_AUDIO_LO && id <= ID_AUDIO_HI) k = KIND_AUDIO;
    else if (id >= ID_VIDEO_LO && id <= ID_VIDEO_HI) k = KIND_VIDEO;
    else k = KIND_INVALID;
    return k;
  endfunction

  function automatic logic kind_has_ext(input logic [2:0] kind);
    return (kind == KIND_PRIV1) || (kind == KIND_AUDIO) || (kind == KIND_VIDEO);
  endfunction

  // Number of timestamp bytes that the indicator calls for.
  function automatic logic [3:0] ts_bytes(input logic [15:0] flags);
    logic [3:0] n;
    case (flags[7:6])
      TS_IND_PTS_DTS: n = 4'd10;
      TS_IND_PTS:     n = 4'd5;
      default:        n = 4'd0;
    endcase
    return n;
  endfunction

  // Fold byte k of a five-byte timestamp into the accumulator.
  function automatic logic [32:0] ts_shift(input logic [32:0] acc, input logic [2:0] k,
                                           input logic [7:0] b);
    logic [32:0] r;
    case (k)
      3'd0:    r = {30'd0, b[3:1]};
      3'd1:    r = {acc[24:0], b};
      3'd2:    r = {acc[25:0], b[7:1]};
      3'd3:    r = {acc[24:0], b};
      default: r = {acc[25:0], b[7:1]};
    endcase
    return r;
  endfunction

  // Position at which a header with an extension is complete.
  function automatic logic [POS_W-1:0] header_end(input logic [7:0] hdr_len,
                                                  input logic [15:0] flags);
    logic [3:0] tsb;
    logic [7:0] span;
    tsb  = ts_bytes(flags);
    span = (hdr_len > {4'd0, tsb}) ? hdr_len : {4'd0, tsb};
    return POS_TS + {1'b0, span};
  endfunction

  // Build a result record from the gathered state.
  function automatic out_item_t build_record(input logic status, input hdr_state_t st);
    out_item_t  r;
    logic [2:0] kind;
    logic       ext;
    logic [3:0] tsb;
    kind = kind_of(st.id);
    ext  = kind_has_ext(kind) && (st.pos >= POS_TS);
    tsb  = ext ? ts_bytes(st.flags) : 4'd0;
    r.status             = status;
    r.start_prefix       = st.prefix;
    r.stream_id          = st.id;
    r.pes_length         = st.length;
    r.stream_kind        = kind;
    r.has_extension      = ext;
    r.extension_flags    = st.flags;
    r.header_data_length = st.hdr_len;
    r.pts_valid          = ext && (tsb >= 4'd5) && (st.pos >= POS_PTS_DONE);
    r.pts_value          = r.pts_valid ? st.pts : 33'd0;
    r.dts_valid          = ext && (tsb >= 4'd10) && (st.pos >= POS_DTS_DONE);
    r.dts_value          = r.dts_valid ? st.dts : 33'd0;
    return r;
  endfunction

endpackage

/* rtl/pesp_out_buf.sv */
module pesp_out_buf
  import pesp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  out_item_t push_data,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      main_valid_r, main_valid_nxt;
  out_item_t main_data_r, main_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_data_r, skid_data_nxt;

  // A new item may be pushed whenever the skid entry is free.
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_item   = main_data_r;

  // Two-entry queue: the skid entry catches an item while the head is stalled.
  always_comb begin
    main_valid_nxt = main_valid_r;
    main_data_nxt  = main_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (main_valid_r && !out_ready) begin
      if (push_valid) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (skid_valid_r) begin
      main_valid_nxt = 1'b1;
      main_data_nxt  = skid_data_r;
      skid_valid_nxt = push_valid;
      skid_data_nxt  = push_data;
    end else begin
      main_valid_nxt = push_valid;
      main_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

/* rtl/pes_header_parser.sv */
// PES header parser. Takes one byte of a PES packet per cycle while in_ready
// is high, with packet_start marking the first byte, and returns one record per
// header: prefix, stream id, length, stream kind, the extension bytes for
// private stream 1, audio and video, and the PTS/DTS when the indicator calls
// for them. A new packet_start before a header is complete returns a record
// with status 1 holding the fields gathered so far. The record is registered
// in the output queue once the byte that completes it is taken.
// Results leave through a two-entry output queue, so in_ready drops only when
// two records are waiting on out_ready. Bytes outside a header give no record.
module pes_header_parser
  import pesp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic       in_header_r, in_header_nxt;
  hdr_state_t st_r, st_nxt;
  logic       accept;
  logic       push_valid;
  logic       push_ready;
  out_item_t  push_data;
  logic [POS_W-1:0] ts_k;
  logic [POS_W-1:0] ts_k_dts;
  logic [3:0] tsb_cur;

  assign accept   = in_valid && in_ready;
  assign in_ready = push_ready;

  // Timestamp byte index for the current position.
  assign ts_k     = st_r.pos - POS_TS;
  assign ts_k_dts = ts_k - TS_ONE_LEN;
  assign tsb_cur  = ts_bytes(st_r.flags);

  // Field gathering and record generation for one byte.
  always_comb begin
    st_nxt        = st_r;
    in_header_nxt = in_header_r;
    push_valid    = 1'b0;
    push_data     = build_record(STATUS_TRUNC, st_r);
    if (accept) begin
      if (in_item.packet_start) begin
        push_valid     = in_header_r;
        st_nxt         = '0;
        st_nxt.prefix  = {16'd0, in_item.data_byte};
        st_nxt.pos     = 9'd1;
        in_header_nxt  = 1'b1;
      end else if (in_header_r) begin
        if (st_r.pos < POS_PREFIX_END) begin
          st_nxt.prefix = {st_r.prefix[15:0], in_item.data_byte};
        end else if (st_r.pos == POS_ID) begin
          st_nxt.id = in_item.data_byte;
        end else if (st_r.pos < POS_LEN_END) begin
          st_nxt.length = {st_r.length[7:0], in_item.data_byte};
        end else if (st_r.pos < POS_FLAGS_END) begin
          st_nxt.flags = {st_r.flags[7:0], in_item.data_byte};
        end else if (st_r.pos == POS_HDR_LEN) begin
          st_nxt.hdr_len = in_item.data_byte;
        end else if (ts_k < {5'd0, tsb_cur}) begin
          if (ts_k < TS_ONE_LEN) begin
            st_nxt.pts = ts_shift(st_r.pts, ts_k[2:0], in_item.data_byte);
          end else begin
            st_nxt.dts = ts_shift(st_r.dts, ts_k_dts[2:0], in_item.data_byte);
          end
        end
        st_nxt.pos = st_r.pos + 9'd1;
        // Short headers end after the length; others after the extension.
        if (((st_nxt.pos == POS_LEN_END) && !kind_has_ext(kind_of(st_nxt.id))) ||
            ((st_nxt.pos >= POS_TS) &&
             (st_nxt.pos >= header_end(st_nxt.hdr_len, st_nxt.flags)))) begin
          push_valid    = 1'b1;
          push_data     = build_record(STATUS_DONE, st_nxt);
          in_header_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r <= 1'b0;
    end else begin
      in_header_r <= in_header_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  // Output queue.
  pesp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  // A completed header leaves the parser idle; a truncated one starts anew.
  a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |=> (in_header_r == $past(push_data.status)))
    else $error("parser state does not follow the record status");

  // The header position never runs past the longest possible header.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_header_r |-> (st_r.pos <= POS_MAX))
    else $error("header position out of range");

  // Timestamps are only reported with a parsed extension.
  a_pts_ext: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_data.pts_valid) |-> push_data.has_extension)
    else $error("PTS reported without extension");

  // A DTS is only reported together with a PTS.
  a_dts_pts: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_data.dts_valid) |-> push_data.pts_valid)
    else $error("DTS reported without PTS");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pesp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned SETTLE_CYCLES = 20;

  // Header gathering state of the predictor.
  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] count;
    logic [23:0]      prefix;
    logic [7:0]       sid;
    logic [15:0]      plen;
    logic [15:0]      flags;
    logic [7:0]       hlen;
    logic [32:0]      pts;
    logic [32:0]      dts;
  } parse_state_t;

  // One row of the directed stimulus; fixed rows carry a record typed in by hand.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       fixed;
    out_item_t  want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  parse_state_t hdr = '0;
  out_item_t    expected_q[$];
  dir_row_t     dir_rows[$];
  logic [7:0]   pkt[$];
  int           errors = 0;
  int unsigned  counted = 0;
  int unsigned  burst_left = 0;

  pes_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sort a stream id into its kind.
  function automatic logic [2:0] classify(input logic [7:0] id);
    if (id == ID_PRIV1) return KIND_PRIV1;
    if (id == ID_PADDING) return KIND_PADDING;
    if (id == ID_PRIV2) return KIND_PRIV2;
    if (id >= ID_AUDIO_LO && id <= ID_AUDIO_HI) return KIND_AUDIO;
    if (id >= ID_VIDEO_LO && id <= ID_VIDEO_HI) return KIND_VIDEO;
    return KIND_INVALID;
  endfunction

  function automatic logic carries_ext(input logic [2:0] kind);
    return kind == KIND_PRIV1 || kind == KIND_AUDIO || kind == KIND_VIDEO;
  endfunction

  // Timestamp bytes called for by the PTS/DTS indicator.
  function automatic logic [3:0] stamp_bytes(input logic [15:0] flags);
    if (flags[7:6] == TS_IND_PTS_DTS) return 4'(2 * TS_ONE_LEN);
    if (flags[7:6] == TS_IND_PTS) return 4'(TS_ONE_LEN);
    return 4'd0;
  endfunction

  // Fold one of the five timestamp bytes into the running value.
  function automatic logic [32:0] fold_stamp(input logic [32:0] acc, input int unsigned k,
                                             input logic [7:0] b);
    logic [40:0] r;
    case (k)
      0: begin
        r = {33'd0, b} >> 1;
        r = r & 41'd7;
      end
      1, 3: r = {acc, b};
      default: r = {1'b0, acc, 7'd0} | {34'd0, b[7:1]};
    endcase
    return r[32:0];
  endfunction

  // Record built from what has been gathered so far.
  function automatic out_item_t snapshot(input logic status, input parse_state_t s);
    out_item_t  r;
    logic [2:0] kind;
    logic       ext;
    logic [3:0] tsb;
    kind = classify(s.sid);
    ext = carries_ext(kind) && s.count >= POS_TS;
    tsb = ext ? stamp_bytes(s.flags) : 4'd0;
    r = '0;
    r.status = status;
    r.start_prefix = s.prefix;
    r.stream_id = s.sid;
    r.pes_length = s.plen;
    r.stream_kind = kind;
    r.has_extension = ext;
    r.extension_flags = s.flags;
    r.header_data_length = s.hlen;
    r.pts_valid = ext && tsb >= TS_ONE_LEN && s.count >= POS_PTS_DONE;
    r.pts_value = r.pts_valid ? s.pts : 33'd0;
    r.dts_valid = ext && tsb >= 2 * TS_ONE_LEN && s.count >= POS_DTS_DONE;
    r.dts_value = r.dts_valid ? s.dts : 33'd0;
    return r;
  endfunction

  // Advance the predicted parser by one byte and return the record it causes.
  task automatic parse_byte(input in_item_t it, output logic emits, output out_item_t rec);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] span;
    logic [3:0]       tsb;
    int unsigned      k;
    emits = 1'b0;
    rec = '0;
    if (it.packet_start) begin
      if (hdr.busy) begin
        emits = 1'b1;
        rec = snapshot(STATUS_TRUNC, hdr);
      end
      hdr = '0;
      hdr.busy = 1'b1;
      hdr.prefix = {16'd0, it.data_byte};
      hdr.count = 9'd1;
    end else if (hdr.busy) begin
      p = hdr.count;
      if (p < POS_PREFIX_END) begin
        hdr.prefix = {hdr.prefix[15:0], it.data_byte};
      end else if (p == POS_ID) begin
        hdr.sid = it.data_byte;
      end else if (p < POS_LEN_END) begin
        hdr.plen = {hdr.plen[7:0], it.data_byte};
      end else if (p < POS_FLAGS_END) begin
        hdr.flags = {hdr.flags[7:0], it.data_byte};
      end else if (p == POS_HDR_LEN) begin
        hdr.hlen = it.data_byte;
      end else begin
        k = 32'(p - POS_TS);
        if (k < stamp_bytes(hdr.flags)) begin
          if (k < TS_ONE_LEN) hdr.pts = fold_stamp(hdr.pts, k, it.data_byte);
          else hdr.dts = fold_stamp(hdr.dts, k - TS_ONE_LEN, it.data_byte);
        end
      end
      hdr.count = p + 9'd1;
      // Kinds without an extension end after the length field.
      if (hdr.count == POS_LEN_END && !carries_ext(classify(hdr.sid))) begin
        emits = 1'b1;
        rec = snapshot(STATUS_DONE, hdr);
        hdr.busy = 1'b0;
      end else if (hdr.count >= POS_TS) begin
        tsb = stamp_bytes(hdr.flags);
        span = {1'b0, (hdr.hlen > {4'd0, tsb}) ? hdr.hlen : {4'd0, tsb}};
        if (hdr.count >= POS_TS + span) begin
          emits = 1'b1;
          rec = snapshot(STATUS_DONE, hdr);
          hdr.busy = 1'b0;
        end
      end
    end
  endtask

  // Offer one item in bursts with random gaps, then predict from the accepted item.
  task automatic offer(input in_item_t it, input logic fixed, input out_item_t want);
    int unsigned gap;
    logic        emits;
    out_item_t   rec;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (it.packet_start || hdr.busy) counted++;
    parse_byte(it, emits, rec);
    if (fixed) expected_q.push_back(want);
    else if (emits) expected_q.push_back(rec);
  endtask

  // Stop offering until every expected record has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] data, input logic start, input logic fixed,
                         input out_item_t want);
    dir_row_t r;
    r.data = data;
    r.start = start;
    r.fixed = fixed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // Build one packet: mostly well formed, with random content and some cut short.
  task automatic make_packet();
    logic [7:0]  sid;
    logic [7:0]  hl;
    logic [15:0] fl;
    int unsigned pick;
    int unsigned span;
    int unsigned cut;
    pkt.delete();
    pick = $urandom_range(0, 19);
    if (pick < 4) sid = 8'($urandom_range(ID_VIDEO_LO, ID_VIDEO_HI));
    else if (pick < 8) sid = 8'($urandom_range(ID_AUDIO_LO, ID_AUDIO_HI));
    else if (pick < 11) sid = ID_PRIV1;
    else if (pick == 11) sid = ID_PADDING;
    else if (pick == 12) sid = ID_PRIV2;
    else sid = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      repeat (3) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back(8'h01);
    end
    pkt.push_back(sid);
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'($urandom_range(0, 255)));
    if (carries_ext(classify(sid))) begin
      fl = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 59);
      if (pick == 0) hl = 8'hFF;
      else if (pick < 4) hl = 8'($urandom_range(15, 254));
      else hl = 8'($urandom_range(0, 14));
      pkt.push_back(fl[15:8]);
      pkt.push_back(fl[7:0]);
      pkt.push_back(hl);
      span = 32'((hl > {4'd0, stamp_bytes(fl)}) ? hl : {4'd0, stamp_bytes(fl)});
      repeat (span) pkt.push_back(8'($urandom_range(0, 255)));
    end
    // Trailing payload bytes are ignored by the parser.
    repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic cmp_field(input string what, input logic [32:0] want, input logic [32:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Compare one accepted record against the oldest expectation.
  task automatic check_record(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: record with nothing expected, expected none, actual %0h", $time, got);
    end else begin
      want = expected_q.pop_front();
      cmp_field("status", 33'(want.status), 33'(got.status));
      cmp_field("start_prefix", 33'(want.start_prefix), 33'(got.start_prefix));
      cmp_field("stream_id", 33'(want.stream_id), 33'(got.stream_id));
      cmp_field("pes_length", 33'(want.pes_length), 33'(got.pes_length));
      cmp_field("stream_kind", 33'(want.stream_kind), 33'(got.stream_kind));
      cmp_field("has_extension", 33'(want.has_extension), 33'(got.has_extension));
      cmp_field("extension_flags", 33'(want.extension_flags), 33'(got.extension_flags));
      cmp_field("header_data_length", 33'(want.header_data_length),
                33'(got.header_data_length));
      cmp_field("pts_valid", 33'(want.pts_valid), 33'(got.pts_valid));
      cmp_field("pts_value", want.pts_value, got.pts_value);
      cmp_field("dts_valid", 33'(want.dts_valid), 33'(got.dts_valid));
      cmp_field("dts_value", want.dts_value, got.dts_value);
    end
  endtask

  // Record monitor.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_record(out_item);
    end
  end

  // Receiver: changing stall patterns, with long hold-offs that fill the block.
  initial begin : sink
    int unsigned cyc;
    int unsigned hold;
    int unsigned mode;
    cyc = 0;
    hold = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cyc == 700 || cyc == 4000) hold = 300;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 3 == 0);
        endcase
      end
      cyc++;
    end
  end

  // Stimulus: directed table, then random packets.
  initial begin
    in_item_t  it;
    out_item_t pad_rec;
    out_item_t cut_rec;
    out_item_t vid_rec;
    logic      paused;

    pad_rec = '0;
    pad_rec.status = STATUS_DONE;
    pad_rec.start_prefix = 24'h000001;
    pad_rec.stream_id = ID_PADDING;
    pad_rec.pes_length = 16'hFFFF;
    pad_rec.stream_kind = KIND_PADDING;

    cut_rec = '0;
    cut_rec.status = STATUS_TRUNC;
    cut_rec.start_prefix = 24'h0000FF;
    cut_rec.stream_kind = KIND_INVALID;

    vid_rec = '0;
    vid_rec.status = STATUS_DONE;
    vid_rec.start_prefix = 24'h000001;
    vid_rec.stream_id = ID_VIDEO_LO;
    vid_rec.stream_kind = KIND_VIDEO;
    vid_rec.has_extension = 1'b1;
    vid_rec.extension_flags = 16'hFFFF;
    vid_rec.pts_valid = 1'b1;
    vid_rec.pts_value = '1;
    vid_rec.dts_valid = 1'b1;
    vid_rec.dts_value = '1;

    // A byte while idle gives nothing.
    add_row(8'hFF, 1'b0, 1'b0, '0);
    // Padding packet with the largest length: done after the length field.
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(ID_PADDING, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, pad_rec);
    // A new packet after one byte truncates the old one.
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, cut_rec);
    // Video with PTS and DTS, all ones, and a header length too short for them.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(ID_VIDEO_LO, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    repeat (9) add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, vid_rec);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      it.data_byte = dir_rows[i].data;
      it.packet_start = dir_rows[i].start;
      offer(it, dir_rows[i].fixed, dir_rows[i].want);
    end
    drain();

    // Random part: mostly packets, some stray bytes and stray starts.
    paused = 1'b0;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          it.data_byte = 8'($urandom_range(0, 255));
          it.packet_start = ($urandom_range(0, 5) == 0);
          offer(it, 1'b0, '0);
        end
      end else begin
        make_packet();
        foreach (pkt[j]) begin
          it.data_byte = pkt[j];
          it.packet_start = (j == 0);
          offer(it, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("pes_header_parser regression: pass");
    end else begin
      $display("pes_header_parser regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("pes_header_parser regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/pesp_pkg.sv
rtl/pesp_out_buf.sv
rtl/pes_header_parser.sv
dv/tb.sv
